// ===== sv/tdfa_pkg.sv =====
// ============================================================================
// tdfa_pkg
// Shared types and constants for the table-driven DFA stepper.
// ============================================================================
`default_nettype none

package tdfa_pkg;

    localparam int unsigned LABEL_W = 8;   // state and symbol characters
    localparam int unsigned SLOT_W  = 4;   // row, column and accept slots
    localparam int unsigned COUNT_W = 5;   // in-use counts
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_STATE_LABEL  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SYMBOL_LABEL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TABLE_ENTRY  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ACCEPT_LABEL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_START        = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STEP         = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STATES_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_COUNT   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  row_slot;
        logic [SLOT_W-1:0]  col_slot;
        logic [LABEL_W-1:0] char_value;
    } t_in_item;

    typedef struct packed {
        logic [LABEL_W-1:0] prev_state;
        logic [LABEL_W-1:0] new_state;
        logic               accepting;
    } t_out_item;

    // Result of a label search: last matching slot
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } t_hit;

    typedef enum logic {
        PH_IDLE,
        PH_LOOKUP
    } t_phase;

endpackage

`default_nettype wire

// ===== sv/table_driven_dfa_stepper.sv =====
// ============================================================================
// table_driven_dfa_stepper
// Table-driven DFA over 8-bit state and symbol labels.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries command beats:
//   state label, symbol label, table entry and accept label loads, start
//   (sets the current state) and step (one input symbol).
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries one beat
//   per step: previous state, new state and the accepting flag.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the three in-use counts;
//   it is always ready. Write it only while the block is idle.
//   Flow: load and start beats are taken back to back. A step does the label
//   search and the next-state table read when it is taken, then the result
//   selection and accept search in the lookup phase. The next step needs the
//   updated current state and the table read is registered, so the input
//   stalls in the lookup phase; a new step waits until the last is done.
//   A finished result sits in the output register; while the receiver
//   stalls it holds, loads keep flowing, and a following step waits in its
//   lookup phase until the register drains.
//   Reset: current state clears to zero, counts return to 1, 1 and 0,
//   the output goes empty. Label and table contents are undefined until
//   written; no clearing pass is run.
// ============================================================================
`default_nettype none

module table_driven_dfa_stepper
    import tdfa_pkg::*;
#(
    parameter int unsigned MAX_STATES  = 16,
    parameter int unsigned MAX_SYMBOLS = 16,
    parameter int unsigned MAX_ACCEPT  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command beats
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    // result beats
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COUNT_W-1:0]   i_cfg_data
);

    // Slots are 4 bits wide, so at most 16 entries per bank are reachable
    localparam int unsigned SLOT_N = 1 << SLOT_W;
    localparam int unsigned NS     = (MAX_STATES  < SLOT_N) ? MAX_STATES  : SLOT_N;
    localparam int unsigned NC     = (MAX_SYMBOLS < SLOT_N) ? MAX_SYMBOLS : SLOT_N;
    localparam int unsigned NA     = (MAX_ACCEPT  < SLOT_N) ? MAX_ACCEPT  : SLOT_N;
    localparam int unsigned TBL_DEPTH = NS * NC;
    localparam int unsigned TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int unsigned FULL_W    = 2 * SLOT_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] r_states_in_use;
    logic [COUNT_W-1:0] r_symbols_in_use;
    logic [COUNT_W-1:0] r_accept_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states_in_use  <= COUNT_W'(1);
            r_symbols_in_use <= COUNT_W'(1);
            r_accept_count   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STATES_IN_USE:  r_states_in_use  <= i_cfg_data;
                CFG_SYMBOLS_IN_USE: r_symbols_in_use <= i_cfg_data;
                CFG_ACCEPT_COUNT:   r_accept_count   <= i_cfg_data;
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic in_beat;
    logic step_beat;
    logic [LABEL_W-1:0] ch;

    assign in_beat   = i_in_valid && !o_in_stall;
    assign step_beat = in_beat && (i_in_data.cmd == CMD_STEP);
    assign ch        = i_in_data.char_value;

    // ------------------------------------------------------------------
    // Label banks
    // ------------------------------------------------------------------
    logic [LABEL_W-1:0] r_cur_state;
    t_hit row_hit;
    t_hit col_hit;
    t_hit acc_hit;
    logic [LABEL_W-1:0] next_state;

    tdfa_labels #(.DEPTH(NS)) u_state_labels (
        .i_clk     (i_clk),
        .i_wr_en   (in_beat && (i_in_data.cmd == CMD_STATE_LABEL)),
        .i_wr_slot (i_in_data.row_slot),
        .i_wr_data (ch),
        .i_key     (r_cur_state),
        .i_count   (r_states_in_use),
        .o_hit     (row_hit)
    );

    tdfa_labels #(.DEPTH(NC)) u_symbol_labels (
        .i_clk     (i_clk),
        .i_wr_en   (in_beat && (i_in_data.cmd == CMD_SYMBOL_LABEL)),
        .i_wr_slot (i_in_data.col_slot),
        .i_wr_data (ch),
        .i_key     (ch),
        .i_count   (r_symbols_in_use),
        .o_hit     (col_hit)
    );

    tdfa_labels #(.DEPTH(NA)) u_accept_labels (
        .i_clk     (i_clk),
        .i_wr_en   (in_beat && (i_in_data.cmd == CMD_ACCEPT_LABEL)),
        .i_wr_slot (i_in_data.row_slot),
        .i_wr_data (ch),
        .i_key     (next_state),
        .i_count   (r_accept_count),
        .o_hit     (acc_hit)
    );

    // ------------------------------------------------------------------
    // Next-state table memory
    // ------------------------------------------------------------------
    logic [FULL_W-1:0] wr_full;
    logic [FULL_W-1:0] rd_full;
    logic              tbl_wr_en;
    logic [LABEL_W-1:0] tbl_rd_data;

    // Row-major slot address: row * NC + column
    assign wr_full = FULL_W'(i_in_data.row_slot) * FULL_W'(NC) + FULL_W'(i_in_data.col_slot);
    assign rd_full = FULL_W'(row_hit.idx) * FULL_W'(NC) + FULL_W'(col_hit.idx);

    // Drop table loads outside the configured array
    assign tbl_wr_en = in_beat && (i_in_data.cmd == CMD_TABLE_ENTRY)
                     && (32'(i_in_data.row_slot) < NS)
                     && (32'(i_in_data.col_slot) < NC);

    tdfa_ram #(.WIDTH(LABEL_W), .DEPTH(TBL_DEPTH)) u_next_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (TBL_AW'(wr_full)),
        .i_wr_data (ch),
        .i_rd_en   (step_beat),
        .i_rd_addr (TBL_AW'(rd_full)),
        .o_rd_data (tbl_rd_data)
    );

    // ------------------------------------------------------------------
    // Step context held across the lookup phase
    // ------------------------------------------------------------------
    logic               r_row_hit;
    logic               r_col_hit;
    logic [LABEL_W-1:0] r_prev;
    logic [LABEL_W-1:0] r_sym;

    always_ff @(posedge i_clk) begin
        if (step_beat) begin
            r_row_hit <= row_hit.hit;
            r_col_hit <= col_hit.hit;
            r_prev    <= r_cur_state;
            r_sym     <= ch;
        end
    end

    // A state-label hit means the label equals the previous state; a
    // symbol-label hit means it equals the input symbol.
    always_comb begin
        priority if (r_row_hit && r_col_hit) begin
            next_state = tbl_rd_data;
        end else if (r_row_hit) begin
            next_state = r_prev;
        end else if (r_col_hit) begin
            next_state = r_sym;
        end else begin
            next_state = '0;
        end
    end

    // ------------------------------------------------------------------
    // Control: idle / lookup
    // ------------------------------------------------------------------
    t_phase r_phase;
    t_phase n_phase;
    logic   out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        o_in_stall = 1'b0;
        out_load   = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (step_beat) begin
                    n_phase = PH_LOOKUP;
                end
            end
            PH_LOOKUP: begin
                o_in_stall = 1'b1;
                // finish only once the output register can take the beat
                if (!o_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_phase  = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Current state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_state <= '0;
        end else if (out_load) begin
            r_cur_state <= next_state;
        end else if (in_beat && (i_in_data.cmd == CMD_START)) begin
            r_cur_state <= ch;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out_data.prev_state <= r_prev;
            o_out_data.new_state  <= next_state;
            o_out_data.accepting  <= acc_hit.hit;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tdfa_ram.sv =====
// ============================================================================
// tdfa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module tdfa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tdfa_labels.sv =====
// ============================================================================
// tdfa_labels
// Label bank: written one slot at a time, searched in parallel for the last
// slot below the in-use count whose label equals the key.
// ============================================================================
`default_nettype none

module tdfa_labels
    import tdfa_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [SLOT_W-1:0]  i_wr_slot,
    input  wire logic [LABEL_W-1:0] i_wr_data,
    input  wire logic [LABEL_W-1:0] i_key,
    input  wire logic [COUNT_W-1:0] i_count,
    output t_hit                    o_hit
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LABEL_W-1:0] r_label [DEPTH];

    // Drop writes to slots beyond the bank
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (32'(i_wr_slot) < DEPTH)) begin
            r_label[i_wr_slot[AW-1:0]] <= i_wr_data;
        end
    end

    always_comb begin
        o_hit = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if ((r_label[i] == i_key) && (COUNT_W'(i) < i_count)) begin
                o_hit.hit = 1'b1;
                o_hit.idx = SLOT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/tdfa_checker.sv =====
// ============================================================================
// tdfa_checker
// Port-level checks on the DFA stepper, bound to the top level.
// ============================================================================
`default_nettype none

module tdfa_checker
    import tdfa_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire t_in_item             i_in_data,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire t_out_item            o_out_data,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [COUNT_W-1:0]   i_cfg_data
);

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    // A step beat holds off the input for its lookup cycle
    a_step_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_in_data.cmd == CMD_STEP) |=> o_in_stall)
        else $error("step beat not followed by input stall");

    // Load and start beats never hold off the following beat
    a_load_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_in_data.cmd != CMD_STEP) |=> !o_in_stall)
        else $error("non-step beat stalled the input");

    // A result appears only out of a lookup cycle
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat without a step lookup");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

endmodule

bind table_driven_dfa_stepper tdfa_checker u_tdfa_checker (.*);

`default_nettype wire

// ===== sim/table_driven_dfa_stepper_test.sv =====
// ----------------------------------------------------------------------------
// table_driven_dfa_stepper_test
// Self-checking bench for the table-driven DFA stepper. Command beats
// (label, table and accept loads, starts and steps) go in with random gaps.
// Results come out against random receiver stalls. A scoreboard class keeps
// its own copy of the label tables, the next-state table, the counts and the
// current state, and checks every result beat in order. A directed opening
// is followed by phases of random automaton traffic under different counts.
// ----------------------------------------------------------------------------
`default_nettype none

module table_driven_dfa_stepper_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tdfa_pkg::*;

    // Command codes the block must ignore, and the register index it has no
    // register behind.
    localparam logic [CMD_W-1:0]     CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0]     CMD_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    localparam int unsigned SLOTS          = 16;
    localparam int unsigned PHASES         = 8;
    localparam int unsigned PHASE_ITEMS    = 240;
    localparam int unsigned IDLE_CYCLES    = 4;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned CYCLE_LIMIT    = 600000;

    typedef logic [SLOTS-1:0][LABEL_W-1:0] t_label_bank;

    // ------------------------------------------------------------------------
    // Scoreboard: automaton shadow plus the queue of expected step results.
    // ------------------------------------------------------------------------
    class dfa_scoreboard;
        t_label_bank          state_lbl;
        t_label_bank          symbol_lbl;
        t_label_bank          accept_lbl;
        logic [LABEL_W-1:0]   next_tbl [SLOTS*SLOTS];
        logic [LABEL_W-1:0]   cur_state;
        logic [COUNT_W-1:0]   n_states;
        logic [COUNT_W-1:0]   n_symbols;
        logic [COUNT_W-1:0]   n_accept;
        t_out_item            expected_q [$];
        int unsigned          failures;

        function new();
            state_lbl  = '0;
            symbol_lbl = '0;
            accept_lbl = '0;
            foreach (next_tbl[i]) next_tbl[i] = '0;
            cur_state = '0;
            n_states  = 1;
            n_symbols = 1;
            n_accept  = 0;
            failures  = 0;
        endfunction

        // Counts above the table size search the whole table.
        function int unsigned clamp(logic [COUNT_W-1:0] v);
            return (v > SLOTS) ? SLOTS : int'(v);
        endfunction

        // Last slot below cnt whose label equals key.
        function t_hit search(t_label_bank bank, int unsigned cnt, logic [LABEL_W-1:0] key);
            t_hit h;
            h = '0;
            for (int i = 0; i < cnt; i++)
                if (bank[i] == key) begin
                    h.hit = 1'b1;
                    h.idx = SLOT_W'(i);
                end
            return h;
        endfunction

        function void write_count(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
            case (idx)
                CFG_STATES_IN_USE:  n_states  = val;
                CFG_SYMBOLS_IN_USE: n_symbols = val;
                CFG_ACCEPT_COUNT:   n_accept  = val;
                default: ;
            endcase
        endfunction

        function void note_input(t_in_item it);
            t_hit               row_h;
            t_hit               col_h;
            logic [LABEL_W-1:0] nxt;
            t_out_item          outcome;
            case (it.cmd)
                CMD_STATE_LABEL:  state_lbl[it.row_slot]  = it.char_value;
                CMD_SYMBOL_LABEL: symbol_lbl[it.col_slot] = it.char_value;
                CMD_TABLE_ENTRY:  next_tbl[{it.row_slot, it.col_slot}] = it.char_value;
                CMD_ACCEPT_LABEL: accept_lbl[it.row_slot] = it.char_value;
                CMD_START:        cur_state = it.char_value;
                CMD_STEP: begin
                    row_h = search(state_lbl, clamp(n_states), cur_state);
                    col_h = search(symbol_lbl, clamp(n_symbols), it.char_value);
                    if (row_h.hit && col_h.hit)
                        nxt = next_tbl[{row_h.idx, col_h.idx}];
                    else if (row_h.hit)
                        nxt = state_lbl[row_h.idx];
                    else if (col_h.hit)
                        nxt = symbol_lbl[col_h.idx];
                    else
                        nxt = '0;
                    outcome.prev_state = cur_state;
                    outcome.new_state  = nxt;
                    outcome.accepting  = search(accept_lbl, clamp(n_accept), nxt).hit;
                    expected_q.push_back(outcome);
                    cur_state = nxt;
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            failures++;
            $display("ERROR @%0t: %s", $realtime, what);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat with nothing expected (prev %h new %h acc %b)",
                                 got.prev_state, got.new_state, got.accepting));
                return;
            end
            want = expected_q.pop_front();
            if (got.prev_state !== want.prev_state)
                report($sformatf("prev_state %h, expected %h", got.prev_state, want.prev_state));
            if (got.new_state !== want.new_state)
                report($sformatf("new_state %h, expected %h", got.new_state, want.new_state));
            if (got.accepting !== want.accepting)
                report($sformatf("accepting %b, expected %b", got.accepting, want.accepting));
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COUNT_W-1:0]   i_cfg_data;

    table_driven_dfa_stepper DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    dfa_scoreboard   sb;
    // Slots written so far: a step is only sent once every entry it reads
    // holds a value.
    logic [SLOTS-1:0]       state_set;
    logic [SLOTS-1:0]       symbol_set;
    logic [SLOTS-1:0]       accept_set;
    logic [SLOTS*SLOTS-1:0] table_set;
    bit                     calm;        // no gaps and no stalls while set
    int unsigned            cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop if the block hangs or loses a result.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Check every result beat the receiver takes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
    end

    // Receiver stalls: mostly short runs, now and then a long one; none at all
    // in calm stretches.
    initial begin
        int unsigned hold;
        logic        level;
        i_out_stall = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                i_out_stall = 1'b0;
                hold = 0;
            end else if (hold == 0) begin
                level = ($urandom_range(99) < 40);
                if (level)
                    hold = ($urandom_range(99) < 80) ? $urandom_range(1, 3)
                                                     : $urandom_range(4, 30);
                else
                    hold = $urandom_range(1, 8);
                i_out_stall = level;
            end else begin
                hold--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item make_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] row,
                                           logic [SLOT_W-1:0] col, logic [LABEL_W-1:0] ch);
        t_in_item it;
        it.cmd        = cmd;
        it.row_slot   = row;
        it.col_slot   = col;
        it.char_value = ch;
        return it;
    endfunction

    // Small alphabet so labels collide and searches hit; some fully random.
    function automatic logic [LABEL_W-1:0] pick_char();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) return 8'h00;
        if (roll < 30) return 8'hFF;
        if (roll < 70) return 8'h61 + 8'($urandom_range(7));
        return 8'($urandom);
    endfunction

    // A label already present among the searched slots, when there is one.
    function automatic logic [LABEL_W-1:0] pick_from(t_label_bank bank, logic [SLOTS-1:0] set,
                                                     logic [COUNT_W-1:0] count);
        int unsigned lim;
        int unsigned slot;
        lim  = sb.clamp(count);
        slot = (lim == 0) ? $urandom_range(SLOTS-1) : $urandom_range(lim-1);
        if (set[slot]) return bank[slot];
        return pick_char();
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Present one command beat and hold it until taken. Enter and leave at a
    // falling edge with valid still high, so back-to-back beats never drop it.
    task automatic send_item(t_in_item it);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        case (it.cmd)
            CMD_STATE_LABEL:  state_set[it.row_slot]  = 1'b1;
            CMD_SYMBOL_LABEL: symbol_set[it.col_slot] = 1'b1;
            CMD_TABLE_ENTRY:  table_set[{it.row_slot, it.col_slot}] = 1'b1;
            CMD_ACCEPT_LABEL: accept_set[it.row_slot] = 1'b1;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Fill every slot the step will read that is still empty, then step.
    task automatic step_with_symbol(logic [LABEL_W-1:0] sym);
        t_hit row_h;
        t_hit col_h;
        for (int i = 0; i < sb.clamp(sb.n_states); i++)
            if (!state_set[i])
                send_item(make_item(CMD_STATE_LABEL, SLOT_W'(i), 4'($urandom), pick_char()));
        for (int i = 0; i < sb.clamp(sb.n_symbols); i++)
            if (!symbol_set[i])
                send_item(make_item(CMD_SYMBOL_LABEL, 4'($urandom), SLOT_W'(i), pick_char()));
        for (int i = 0; i < sb.clamp(sb.n_accept); i++)
            if (!accept_set[i])
                send_item(make_item(CMD_ACCEPT_LABEL, SLOT_W'(i), 4'($urandom),
                                    pick_from(sb.state_lbl, state_set, sb.n_states)));
        row_h = sb.search(sb.state_lbl, sb.clamp(sb.n_states), sb.cur_state);
        col_h = sb.search(sb.symbol_lbl, sb.clamp(sb.n_symbols), sym);
        if (row_h.hit && col_h.hit && !table_set[{row_h.idx, col_h.idx}])
            send_item(make_item(CMD_TABLE_ENTRY, row_h.idx, col_h.idx,
                                pick_from(sb.state_lbl, state_set, sb.n_states)));
        send_item(make_item(CMD_STEP, 4'($urandom), 4'($urandom), sym));
    endtask

    task automatic set_count(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_count(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drop valid, let every expected result drain, then idle the input so
    // that a trailing load or start can retire.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One beat of random automaton traffic, weighted toward steps that walk
    // through programmed states.
    task automatic random_item();
        int unsigned        roll;
        logic [LABEL_W-1:0] ch;
        logic [CMD_W-1:0]   spare;
        roll = $urandom_range(99);
        if (roll < 52) begin
            ch = ($urandom_range(99) < 65) ? pick_from(sb.symbol_lbl, symbol_set, sb.n_symbols)
                                          : pick_char();
            step_with_symbol(ch);
        end else if (roll < 67) begin
            ch = ($urandom_range(99) < 80) ? pick_from(sb.state_lbl, state_set, sb.n_states)
                                          : pick_char();
            send_item(make_item(CMD_TABLE_ENTRY, 4'($urandom), 4'($urandom), ch));
        end else if (roll < 74) begin
            send_item(make_item(CMD_STATE_LABEL, 4'($urandom), 4'($urandom), pick_char()));
        end else if (roll < 81) begin
            send_item(make_item(CMD_SYMBOL_LABEL, 4'($urandom), 4'($urandom), pick_char()));
        end else if (roll < 87) begin
            ch = ($urandom_range(99) < 70) ? pick_from(sb.state_lbl, state_set, sb.n_states)
                                          : pick_char();
            send_item(make_item(CMD_ACCEPT_LABEL, 4'($urandom), 4'($urandom), ch));
        end else if (roll < 95) begin
            ch = ($urandom_range(99) < 75) ? pick_from(sb.state_lbl, state_set, sb.n_states)
                                          : pick_char();
            send_item(make_item(CMD_START, 4'($urandom), 4'($urandom), ch));
        end else begin
            spare = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
            send_item(make_item(spare, 4'($urandom), 4'($urandom), 8'($urandom)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    int unsigned phase_states  [PHASES] = '{16, 0, 31, 1, 17, 3, 16, 8};
    int unsigned phase_symbols [PHASES] = '{16, 1, 31, 0, 20, 16, 2, 5};
    int unsigned phase_accept  [PHASES] = '{16, 0, 31, 1, 2, 17, 16, 4};

    initial begin
        sb = new();
        state_set   = '0;
        symbol_set  = '0;
        accept_set  = '0;
        table_set   = '0;
        calm        = 1'b1;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening: two rows, two columns, one accepting label.
        set_count(CFG_STATES_IN_USE, 5'd2);
        set_count(CFG_SYMBOLS_IN_USE, 5'd2);
        set_count(CFG_ACCEPT_COUNT, 5'd1);
        send_item(make_item(CMD_STATE_LABEL,  4'h0, 4'h0, 8'h41));
        send_item(make_item(CMD_STATE_LABEL,  4'h1, 4'hF, 8'hFF));
        send_item(make_item(CMD_SYMBOL_LABEL, 4'hF, 4'h0, 8'h00));
        send_item(make_item(CMD_SYMBOL_LABEL, 4'h0, 4'h1, 8'h30));
        send_item(make_item(CMD_TABLE_ENTRY,  4'h0, 4'h0, 8'hFF));
        send_item(make_item(CMD_TABLE_ENTRY,  4'h0, 4'h1, 8'h41));
        send_item(make_item(CMD_TABLE_ENTRY,  4'h1, 4'h0, 8'h00));
        send_item(make_item(CMD_TABLE_ENTRY,  4'h1, 4'h1, 8'h41));
        send_item(make_item(CMD_TABLE_ENTRY,  4'hF, 4'hF, 8'hFF));
        send_item(make_item(CMD_ACCEPT_LABEL, 4'h0, 4'h0, 8'hFF));
        send_item(make_item(CMD_ACCEPT_LABEL, 4'hF, 4'hF, 8'h00));
        // Spare command codes: no effect, no result.
        send_item(make_item(CMD_SPARE_6, 4'hF, 4'hF, 8'hFF));
        send_item(make_item(CMD_SPARE_7, 4'h0, 4'h0, 8'h00));
        send_item(make_item(CMD_START, 4'hF, 4'h0, 8'h41));
        step_with_symbol(8'h00);        // both hit: table read, accepting
        step_with_symbol(8'h30);        // both hit from the other row
        step_with_symbol(8'h7A);        // state hit, unknown symbol: stay put
        send_item(make_item(CMD_START, 4'h0, 4'hF, 8'h99));
        step_with_symbol(8'h30);        // unknown state: take the symbol label
        send_item(make_item(CMD_START, 4'h5, 4'hA, 8'h99));
        step_with_symbol(8'h55);        // neither known: fall to zero
        send_item(make_item(CMD_STATE_LABEL, 4'h1, 4'h0, 8'h41));
        send_item(make_item(CMD_START, 4'hA, 4'h5, 8'h41));
        step_with_symbol(8'h00);        // duplicate label: last row wins
        step_with_symbol(8'hFF);        // from zero, nothing matches

        // Random phases, each under its own counts, extremes included.
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            calm = (p == 1 || p == 5);
            if (p == PHASES - 1) begin
                phase_states[p]  = $urandom_range(31);
                phase_symbols[p] = $urandom_range(31);
                phase_accept[p]  = $urandom_range(31);
            end
            set_count(CFG_STATES_IN_USE,  COUNT_W'(phase_states[p]));
            set_count(CFG_SYMBOLS_IN_USE, COUNT_W'(phase_symbols[p]));
            set_count(CFG_ACCEPT_COUNT,   COUNT_W'(phase_accept[p]));
            if (p == 2)
                set_count(CFG_SPARE, COUNT_W'($urandom));
            repeat (PHASE_ITEMS) random_item();
        end

        // Drain, then keep the clock running so that any stray beat is caught.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/tdfa_pkg.sv
sv/tdfa_ram.sv
sv/tdfa_labels.sv
sv/table_driven_dfa_stepper.sv
sv/tdfa_checker.sv
sim/table_driven_dfa_stepper_test.sv
